// ----- rtl/pdk_pkg.sv -----
package pdk_pkg;

    // Fixed point format of the distance and the weight
    localparam int FRAC_BITS = 16;
    localparam int DIST_W    = 20;
    localparam int WEIGHT_W  = 16;
    localparam int OUT_FRAC  = 16;

    // Square root: radicand in [2^(2F), 2^(2F+1)], root below 2^(F+1)
    localparam int ROOT_W = FRAC_BITS + 1;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 1;

    // Front end arithmetic width: holds distance and 2.0 with headroom for 5.0
    localparam int CMP_W = (DIST_W > FRAC_BITS + 2) ? DIST_W : FRAC_BITS + 2;
    localparam int ARG_W = CMP_W + 2;

    // Numerator (3 - 2r + s near, 5 - 2r - s far) below 5.0, F fraction bits
    localparam int NUM_W     = FRAC_BITS + 3;
    localparam int NUM_SHIFT = FRAC_BITS + 3;

    localparam logic [RAD_W-1:0] RAD_ONE = RAD_W'(1) << (2 * FRAC_BITS);
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = WEIGHT_W'(1) << (OUT_FRAC - 1);

    // Which branch of the kernel a distance falls in
    typedef enum logic [1:0] {
        KIND_NEAR,
        KIND_FAR,
        KIND_ZERO
    } pdk_kind_t;

    // Payload handed from cell to cell along the root chain
    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [NUM_W-1:0]  base;
        pdk_kind_t         kind;
    } pdk_cell_t;

endpackage

// ----- rtl/pdk_prep.sv -----
module pdk_prep (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pdk_pkg::DIST_W-1:0]    in_distance,
    output logic                          out_valid,
    input  logic                          out_ready,
    output pdk_pkg::pdk_cell_t            out_item
);
    import pdk_pkg::*;

    // Stage A: branch decode and multiplier operands
    logic                 a_valid_reg, a_valid_next, a_ready;
    logic [ROOT_W-1:0]    a_opa_reg, a_opb_reg, a_opa_next, a_opb_next;
    logic [NUM_W-1:0]     a_base_reg, a_base_next;
    pdk_kind_t            a_kind_reg, a_kind_next;

    // Stage B: product
    logic                 b_valid_reg, b_valid_next, b_ready;
    logic [RAD_W-1:0]     b_prod_reg;
    logic [NUM_W-1:0]     b_base_reg;
    pdk_kind_t            b_kind_reg;

    // Stage C: radicand
    logic                 c_valid_reg, c_valid_next, c_ready;
    logic [RAD_W-1:0]     c_rad_reg, c_rad_next;
    logic [NUM_W-1:0]     c_base_reg;
    pdk_kind_t            c_kind_reg;

    logic [ARG_W-1:0] d_ext, one_w, two_one, three_one, five_one, two_d;
    logic [ARG_W-1:0] near_b, far_u, near_base, far_base;

    // Ready chain: a stage takes a beat when empty or when it drains
    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    assign a_valid_next = a_ready ? in_valid    : a_valid_reg;
    assign b_valid_next = b_ready ? a_valid_reg : b_valid_reg;
    assign c_valid_next = c_ready ? b_valid_reg : c_valid_reg;

    // Decode the branch and form operands and base numerator
    always_comb begin
        d_ext     = ARG_W'(in_distance);
        one_w     = ARG_W'(1) << FRAC_BITS;
        two_one   = one_w << 1;
        three_one = two_one + one_w;
        five_one  = (two_one << 1) + one_w;
        two_d     = d_ext << 1;
        near_b    = one_w - d_ext;
        far_u     = (two_d >= three_one) ? (two_d - three_one) : (three_one - two_d);
        near_base = three_one - two_d;
        far_base  = five_one - two_d;
        if (d_ext <= one_w) begin
            a_kind_next = KIND_NEAR;
            a_opa_next  = d_ext[ROOT_W-1:0];
            a_opb_next  = near_b[ROOT_W-1:0];
            a_base_next = near_base[NUM_W-1:0];
        end else if (d_ext <= two_one) begin
            a_kind_next = KIND_FAR;
            a_opa_next  = far_u[ROOT_W-1:0];
            a_opb_next  = far_u[ROOT_W-1:0];
            a_base_next = far_base[NUM_W-1:0];
        end else begin
            a_kind_next = KIND_ZERO;
            a_opa_next  = '0;
            a_opb_next  = '0;
            a_base_next = '0;
        end
    end

    // Form the radicand: 1 + 4r(1-r) near, 2 - (2r-3)^2 far
    always_comb begin
        unique case (b_kind_reg)
            KIND_NEAR: c_rad_next = RAD_ONE + (b_prod_reg << 2);
            KIND_FAR:  c_rad_next = (RAD_ONE << 1) - b_prod_reg;
            default:   c_rad_next = '0;
        endcase
    end

    // Hold valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (a_ready) begin
            a_opa_reg  <= a_opa_next;
            a_opb_reg  <= a_opb_next;
            a_base_reg <= a_base_next;
            a_kind_reg <= a_kind_next;
        end
        if (b_ready) begin
            b_prod_reg <= a_opa_reg * a_opb_reg;
            b_base_reg <= a_base_reg;
            b_kind_reg <= a_kind_reg;
        end
        if (c_ready) begin
            c_rad_reg  <= c_rad_next;
            c_base_reg <= b_base_reg;
            c_kind_reg <= b_kind_reg;
        end
    end

    assign out_valid      = c_valid_reg;
    assign out_item.rad   = c_rad_reg;
    assign out_item.rem   = '0;
    assign out_item.root  = '0;
    assign out_item.base  = c_base_reg;
    assign out_item.kind  = c_kind_reg;

    // Radicand of a live branch stays within [1, 2]
    assert property (@(posedge aclk) disable iff (!aresetn)
        (c_valid_reg && c_kind_reg != KIND_ZERO) |->
            (c_rad_reg >= RAD_ONE && c_rad_reg <= (RAD_ONE << 1)))
        else $error("radicand out of range");

endmodule

// ----- rtl/pdk_root_cell.sv -----
module pdk_root_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  pdk_pkg::pdk_cell_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output pdk_pkg::pdk_cell_t out_item
);
    import pdk_pkg::*;

    logic               valid_reg, valid_next;
    pdk_cell_t          item_reg, item_next;
    logic [REM_W+1:0]   work, trial, diff;
    logic               fits;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    // One root digit: bring down two radicand bits, try subtracting 4q+1
    always_comb begin
        work  = {in_item.rem, in_item.rad[RAD_W-1 -: 2]};
        trial = (REM_W+2)'({in_item.root, 2'b01});
        fits  = work >= trial;
        diff  = work - trial;
        item_next      = in_item;
        item_next.rad  = in_item.rad << 2;
        item_next.rem  = fits ? diff[REM_W-1:0] : work[REM_W-1:0];
        item_next.root = {in_item.root[ROOT_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // Partial remainder never exceeds twice the partial root
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> ((REM_W+1)'(item_reg.rem) <= ((REM_W+1)'(item_reg.root) << 1)))
        else $error("root remainder too large");

endmodule

// ----- rtl/pdk_post.sv -----
module pdk_post (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  pdk_pkg::pdk_cell_t            in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pdk_pkg::WEIGHT_W-1:0]  out_weight
);
    import pdk_pkg::*;

    logic                          valid_reg, valid_next;
    logic [WEIGHT_W-1:0]           weight_reg, weight_next;
    logic [NUM_W-1:0]              num, root_ext;
    logic [NUM_W+OUT_FRAC-1:0]     scaled;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    // Add or drop the root, then divide by 8 and rescale to the output format
    always_comb begin
        root_ext = NUM_W'(in_item.root);
        unique case (in_item.kind)
            KIND_NEAR: num = in_item.base + root_ext;
            KIND_FAR:  num = in_item.base - root_ext;
            default:   num = '0;
        endcase
        scaled      = {num, {OUT_FRAC{1'b0}}} >> NUM_SHIFT;
        weight_next = scaled[WEIGHT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            weight_reg <= weight_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_weight = weight_reg;

    // Weight peaks at one half
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> weight_reg <= WEIGHT_MAX)
        else $error("weight above one half");

endmodule

// ----- rtl/peskin_delta_kernel.sv -----
// Channel  | Ports                          | Beat
// ---------+--------------------------------+------------------------------------
// input    | s_valid, s_ready, s_distance   | one distance, unsigned Q4.16
// output   | m_valid, m_ready, m_weight     | one weight, unsigned Q0.16
//
// Accepts one distance per cycle unless the output stalls; each beat passes
// FRAC_BITS + 5 register stages (21 at Q4.16): three front-end stages, one root
// cell per root bit, one output stage. Throughput is one beat per cycle unless the
// output stalls.
// Reset (aresetn low, synchronous) empties every stage.
// A stalled output holds its beat; upstream stages keep filling empty slots.
module peskin_delta_kernel (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [pdk_pkg::DIST_W-1:0]    s_distance,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pdk_pkg::WEIGHT_W-1:0]  m_weight
);
    import pdk_pkg::*;

    logic      link_valid [ROOT_W+1];
    logic      link_ready [ROOT_W+1];
    pdk_cell_t link_item  [ROOT_W+1];

    // Front end: branch, product, radicand
    pdk_prep u_prep (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_distance (s_distance),
        .out_valid   (link_valid[0]),
        .out_ready   (link_ready[0]),
        .out_item    (link_item[0])
    );

    // Root cells, one result bit each
    for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
        pdk_root_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (link_valid[i]),
            .in_ready  (link_ready[i]),
            .in_item   (link_item[i]),
            .out_valid (link_valid[i+1]),
            .out_ready (link_ready[i+1]),
            .out_item  (link_item[i+1])
        );
    end

    // Numerator and output register
    pdk_post u_post (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (link_valid[ROOT_W]),
        .in_ready   (link_ready[ROOT_W]),
        .in_item    (link_item[ROOT_W]),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_weight (m_weight)
    );

    // Input backpressure only when the whole chain is full and the output stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled with room in chain");

    // Out of reset the chain is empty
    assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("chain not empty after reset");

endmodule
